// File: rtl/pfh_pkg.sv
// Package for the path fingerprint hash block: constants, payload words,
// and the command and status words between controller and datapath.
// Depends on nothing; every other file of the block uses it.
package pfh_pkg;

  // Hash constants.
  localparam logic [63:0] OFFSET_PRI  = 64'd14695981039346656037;
  localparam logic [63:0] OFFSET_SEC  = 64'd1099511628211;
  localparam logic [63:0] GOLDEN      = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] PATH_MARKER = 64'h4d4f44554c455f49;

  // Primes split into 32-bit halves for the partial products.
  localparam logic [31:0] PRIME_PRI_LO = 32'h000001b3;
  localparam logic [31:0] PRIME_PRI_HI = 32'h00000100;
  localparam logic [31:0] PRIME_SEC_LO = 32'h27d4eb4f;
  localparam logic [31:0] PRIME_SEC_HI = 32'hc2b2ae3d;

  // Mode codes of an input word.
  localparam logic [1:0] MODE_DATA   = 2'd0;
  localparam logic [1:0] MODE_PART   = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Where the byte being mixed comes from.
  typedef enum logic [1:0] {
    SRC_MARKER = 2'd0,
    SRC_INDEX  = 2'd1,
    SRC_DATA   = 2'd2
  } byte_src_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic [63:0] primary_hash;
    logic [63:0] secondary_hash;
    logic [31:0] mixed_byte_count;
    logic [31:0] part_count;
    logic [63:0] path_id;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;      // capture the accepted input word
    logic      mul;       // register the partial products of one byte
    logic      add;       // fold partial products into the accumulators
    byte_src_t src;       // byte source for the multiply step
    logic [2:0] pos;      // byte position within the source word
    logic      part_inc;  // advance the part counter
    logic      fix;       // apply the zero fix to both halves
    logic      mix;       // first combine step
    logic      emit;      // second combine step, load output, clear path
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       part_zero;
    logic       out_free;
  } status_t;

  // Boost-style combine, modulo 2^64.
  function automatic logic [63:0] mix64(input logic [63:0] s, input logic [63:0] v);
    mix64 = s ^ (v + GOLDEN + (s << 6) + (s >> 2));
  endfunction

endpackage

// File: rtl/path_fingerprint_hash_top.sv
// Path fingerprint hash: an FNV-1a 64 primary half and a second
// multiplicative half over a streamed multi-part path, with a combined id.
// A data word is taken, then its byte mixed: the 64-bit multiplies are split
// into 32-bit partial products, registered, and summed in the next cycle.
// A part opening first mixes its 8 index bytes, the first word of a path the
// 8 marker bytes and a decide step; a finish word steps through fix, mix and
// emit, waiting there for the output register to be free.
// Depends on pfh_pkg, pfh_ctrl and pfh_datapath.
module path_fingerprint_hash_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfh_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output pfh_pkg::out_word_t out_word
);

  pfh_pkg::cmd_t    cmd;
  pfh_pkg::status_t status;

  // Sequencer.
  pfh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_word.mode),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  // Hash datapath and output register.
  pfh_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_word),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule

// File: rtl/pfh_ctrl.sv
// Controller of the path fingerprint hash block: sequences marker, part index
// and data bytes through the datapath and steps the finish.
// Depends on pfh_pkg.
module pfh_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  output logic              in_ready,
  output pfh_pkg::cmd_t     cmd,
  input  pfh_pkg::status_t  status
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DECIDE = 7'b0000010,
    S_MUL    = 7'b0000100,
    S_ADD    = 7'b0001000,
    S_FIX    = 7'b0010000,
    S_MIX    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t             state, state_next;
  pfh_pkg::byte_src_t src, src_next;
  logic [2:0]         pos, pos_next;
  logic               marker_done, marker_done_next;
  logic [1:0]         mode_sel;
  logic               route_idle;
  logic               route_fix;
  pfh_pkg::byte_src_t route_src;

  // Choose the next piece of work for the current word.
  always_comb begin
    mode_sel = (state == S_IDLE) ? in_mode : status.mode;
    route_idle = 1'b0;
    route_fix  = 1'b0;
    route_src  = pfh_pkg::SRC_DATA;
    if (mode_sel == pfh_pkg::MODE_NONE) begin
      route_idle = 1'b1;
    end else if (!marker_done) begin
      route_src = pfh_pkg::SRC_MARKER;
    end else if (mode_sel == pfh_pkg::MODE_FINISH) begin
      route_fix = 1'b1;
    end else if (mode_sel == pfh_pkg::MODE_PART || status.part_zero) begin
      route_src = pfh_pkg::SRC_INDEX;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next       = state;
    src_next         = src;
    pos_next         = pos;
    marker_done_next = marker_done;
    in_ready         = 1'b0;
    cmd              = '0;
    cmd.src          = src;
    cmd.pos          = pos;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          pos_next = 3'd0;
          src_next = route_src;
          if (route_idle) begin
            state_next = S_IDLE;
          end else if (route_fix) begin
            state_next = S_FIX;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_DECIDE: begin
        pos_next = 3'd0;
        src_next = route_src;
        if (route_idle) begin
          state_next = S_IDLE;
        end else if (route_fix) begin
          state_next = S_FIX;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        case (src)
          pfh_pkg::SRC_MARKER: begin
            if (pos == 3'd7) begin
              marker_done_next = 1'b1;
              state_next       = S_DECIDE;
            end else begin
              pos_next   = pos + 3'd1;
              state_next = S_MUL;
            end
          end
          pfh_pkg::SRC_INDEX: begin
            if (pos == 3'd7) begin
              cmd.part_inc = 1'b1;
              if (status.mode == pfh_pkg::MODE_DATA) begin
                src_next   = pfh_pkg::SRC_DATA;
                pos_next   = 3'd0;
                state_next = S_MUL;
              end else begin
                state_next = S_IDLE;
              end
            end else begin
              pos_next   = pos + 3'd1;
              state_next = S_MUL;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix    = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // Wait here until the output register can take the word.
        if (status.out_free) begin
          cmd.emit         = 1'b1;
          marker_done_next = 1'b0;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      src         <= pfh_pkg::SRC_MARKER;
      pos         <= 3'd0;
      marker_done <= 1'b0;
    end else begin
      state       <= state_next;
      src         <= src_next;
      pos         <= pos_next;
      marker_done <= marker_done_next;
    end
  end

endmodule

// File: rtl/pfh_datapath.sv
// Datapath of the path fingerprint hash block: accumulators, split 64-bit
// multiplies, counters, finish combine and the output register.
// Depends on pfh_pkg.
module pfh_datapath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  pfh_pkg::in_word_t  in_word,
  input  pfh_pkg::cmd_t      cmd,
  output pfh_pkg::status_t   status,
  output logic               out_valid,
  input  logic               out_ready,
  output pfh_pkg::out_word_t out_word
);

  localparam int CNT_W = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

  pfh_pkg::in_word_t item;
  logic [63:0]       acc_p, acc_s;
  logic [CNT_W-1:0]  cnt;
  logic [31:0]       part_idx;
  logic [63:0]       pp_p_ll, pp_s_ll;
  logic [31:0]       pp_p_hl, pp_p_lh, pp_s_hl, pp_s_lh;
  logic [63:0]       fix_p, fix_s, mix1;

  logic [63:0] src_word, src_shift, x_p, x_s, gid;
  logic [7:0]  b;
  logic [63:0] ll_p, ll_s;
  logic [31:0] hl_p, lh_p, hl_s, lh_s;

  // Pick the byte to mix and form both multiplicands.
  always_comb begin
    case (cmd.src)
      pfh_pkg::SRC_MARKER: src_word = pfh_pkg::PATH_MARKER;
      pfh_pkg::SRC_INDEX:  src_word = {32'd0, part_idx};
      pfh_pkg::SRC_DATA:   src_word = {56'd0, item.data_byte};
      default:             src_word = 64'd0;
    endcase
    src_shift = src_word >> {cmd.pos, 3'b000};
    b   = src_shift[7:0];
    x_p = acc_p ^ {56'd0, b};
    x_s = acc_s ^ ({56'd0, b} + pfh_pkg::GOLDEN);
  end

  // Partial products of a 64-bit multiply kept modulo 2^64.
  assign ll_p = 64'(x_p[31:0]) * 64'(pfh_pkg::PRIME_PRI_LO);
  assign hl_p = x_p[63:32] * pfh_pkg::PRIME_PRI_LO;
  assign lh_p = x_p[31:0] * pfh_pkg::PRIME_PRI_HI;
  assign ll_s = 64'(x_s[31:0]) * 64'(pfh_pkg::PRIME_SEC_LO);
  assign hl_s = x_s[63:32] * pfh_pkg::PRIME_SEC_LO;
  assign lh_s = x_s[31:0] * pfh_pkg::PRIME_SEC_HI;

  // Final combine of the path.
  always_comb begin
    gid = pfh_pkg::mix64(mix1, {32'd0, part_idx});
    if (gid == 64'd0) begin
      gid = pfh_pkg::PATH_MARKER;
    end
  end

  assign status.mode      = item.mode;
  assign status.part_zero = (part_idx == 32'd0);
  assign status.out_free  = !out_valid || out_ready;

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_word;
    end
    if (cmd.mul) begin
      pp_p_ll <= ll_p;
      pp_p_hl <= hl_p;
      pp_p_lh <= lh_p;
      pp_s_ll <= ll_s;
      pp_s_hl <= hl_s;
      pp_s_lh <= lh_s;
    end
    if (cmd.fix) begin
      fix_p <= (acc_p == 64'd0) ? pfh_pkg::OFFSET_PRI : acc_p;
      fix_s <= (acc_s == 64'd0) ? pfh_pkg::OFFSET_SEC : acc_s;
    end
    if (cmd.mix) begin
      mix1 <= pfh_pkg::mix64(fix_p, fix_s);
    end
    if (cmd.emit) begin
      out_word.primary_hash     <= fix_p;
      out_word.secondary_hash   <= fix_s;
      out_word.mixed_byte_count <= 32'(cnt);
      out_word.part_count       <= part_idx;
      out_word.path_id          <= gid;
    end
  end

  // Path state: accumulators and counters, cleared by reset and by emit.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      acc_p    <= pfh_pkg::OFFSET_PRI;
      acc_s    <= pfh_pkg::OFFSET_SEC;
      cnt      <= '0;
      part_idx <= 32'd0;
    end else begin
      if (cmd.add) begin
        acc_p <= pp_p_ll + {pp_p_hl + pp_p_lh, 32'd0};
        acc_s <= pp_s_ll + {pp_s_hl + pp_s_lh, 32'd0};
        if (cnt != {CNT_W{1'b1}}) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.part_inc) begin
        part_idx <= part_idx + 32'd1;
      end
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
